// ===== sv/lcats_pkg.sv =====
`default_nettype none

package lcats_pkg;

  // Field and datapath widths
  localparam int SAMPLE_WIDTH = 24;
  localparam int SUM_WIDTH    = 32;
  localparam int AVG_W        = 24;
  localparam int OFFSET_W     = 24;
  localparam int WEIGHT_W     = 32;
  localparam int CAL_W        = 32;
  localparam int COUNT_W      = 8;
  localparam int TIMEOUT_W    = 16;
  localparam int ELAPSED_W    = 17;

  // Difference of mean and offset, and its Q25.24 scaled form
  localparam int DIFF_W     = AVG_W + 1;
  localparam int FRAC_SHIFT = 24;
  localparam int PROD_W     = DIFF_W + FRAC_SHIFT;

  // Shared divider sizing
  localparam int DIVD_W = (SUM_WIDTH > PROD_W) ? SUM_WIDTH : PROD_W;
  localparam int DVS_W  = CAL_W;
  localparam int STEP_W = $clog2(DIVD_W + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_FACTOR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_NEGATIVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 3'd4;

  localparam logic [COUNT_W-1:0]   RST_AVERAGE_COUNT  = 8'd1;
  localparam logic [OFFSET_W-1:0]  RST_ZERO_OFFSET    = 24'd0;
  localparam logic [CAL_W-1:0]     RST_CAL_FACTOR     = 32'd65536;
  localparam logic                 RST_ALLOW_NEGATIVE = 1'b1;
  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_TICKS  = 16'd1000;

  // Input opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic                           opcode;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [AVG_W-1:0]    average;
    logic signed [WEIGHT_W-1:0] weight_q8;
    logic                       timed_out;
    logic                       range_error;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIVD_W-1:0] dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/load_cell_average_tare_scale.sv =====
// Load cell averager with tare and calibration scaling.
//
// Input channel (in_valid/in_ready/in_data) carries either a conversion
// sample or a millisecond tick. Samples are summed until average_count have
// arrived; the window then yields one result transaction on the output
// channel (out_valid/out_ready/out_data) with the truncated mean and the
// Q24.8 weight. A tick that pushes the window past timeout_ticks closes it
// with a timeout result. Configuration writes use cfg_valid/cfg_index/
// cfg_data; cfg_ready is always high.
//
// Sequencing: a window-closing sample runs the mean division (32 divider
// steps), then the weight division (49 steps), which a zero factor skips.
// A timeout tick goes straight to the result stage; other ticks and samples
// are absorbed while idle. in_ready is low until the result is registered.
//
// Reset (synchronous, rst_n low) loads the register defaults and clears the
// window. A stalled receiver holds the result in the output register; the
// next window is still accepted, and its result waits until the slot frees.
`default_nettype none

module load_cell_average_tare_scale (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire lcats_pkg::in_item_t                  in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output lcats_pkg::out_item_t                      out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [lcats_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lcats_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SUM_WIDTH  = lcats_pkg::SUM_WIDTH;
  localparam int AVG_W      = lcats_pkg::AVG_W;
  localparam int OFFSET_W   = lcats_pkg::OFFSET_W;
  localparam int WEIGHT_W   = lcats_pkg::WEIGHT_W;
  localparam int CAL_W      = lcats_pkg::CAL_W;
  localparam int COUNT_W    = lcats_pkg::COUNT_W;
  localparam int TIMEOUT_W  = lcats_pkg::TIMEOUT_W;
  localparam int ELAPSED_W  = lcats_pkg::ELAPSED_W;
  localparam int DIFF_W     = lcats_pkg::DIFF_W;
  localparam int FRAC_SHIFT = lcats_pkg::FRAC_SHIFT;
  localparam int PROD_W     = lcats_pkg::PROD_W;
  localparam int DIVD_W     = lcats_pkg::DIVD_W;
  localparam int DVS_W      = lcats_pkg::DVS_W;
  localparam int STEP_W     = lcats_pkg::STEP_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START1 = 3'd1;
  localparam logic [2:0] S_WAIT1  = 3'd2;
  localparam logic [2:0] S_DIFF   = 3'd3;
  localparam logic [2:0] S_START2 = 3'd4;
  localparam logic [2:0] S_WAIT2  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // Saturation limits
  localparam logic [AVG_W-1:0]     AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
  localparam logic [AVG_W-1:0]     AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};
  localparam logic [SUM_WIDTH-1:0] AVG_LIM = SUM_WIDTH'(AVG_MAX);
  localparam logic [WEIGHT_W-1:0]  W_MAX   = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0]  W_MIN   = {1'b1, {(WEIGHT_W-1){1'b0}}};
  localparam logic [PROD_W-1:0]    W_LIM   = PROD_W'(W_MAX);

  // Configuration registers
  logic [COUNT_W-1:0]          avg_count_r;
  logic signed [OFFSET_W-1:0]  zero_offset_r;
  logic signed [CAL_W-1:0]     cal_r;
  logic                        allow_neg_r;
  logic [TIMEOUT_W-1:0]        timeout_r;

  // Window and sequencer state
  logic [2:0]                  state_r, state_nxt;
  logic [SUM_WIDTH-1:0]        sum_r, sum_nxt;
  logic [COUNT_W-1:0]          taken_r, taken_nxt;
  logic [ELAPSED_W-1:0]        elapsed_r, elapsed_nxt;

  // Result working registers
  logic signed [AVG_W-1:0]     avg_r, avg_nxt;
  logic signed [DIFF_W-1:0]    diff_r, diff_nxt;
  logic [WEIGHT_W-1:0]         weight_r, weight_nxt;
  logic                        to_r, to_nxt;
  logic                        err_r, err_nxt;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  lcats_pkg::out_item_t        out_data_r, out_data_nxt;

  // Shared divider
  lcats_pkg::div_req_t         div_req;
  lcats_pkg::div_rsp_t         div_rsp;

  logic                        in_fire;
  logic                        out_free;
  logic [COUNT_W-1:0]          count_eff;
  logic [COUNT_W-1:0]          taken_inc;
  logic [SUM_WIDTH-1:0]        sample_ext;
  logic [ELAPSED_W-1:0]        elapsed_inc;
  logic                        tick_timeout;
  logic [SUM_WIDTH-1:0]        sum_mag;
  logic [CAL_W-1:0]            cal_mag;
  logic [DIFF_W-1:0]           diff_mag;
  logic [PROD_W-1:0]           prod_mag;
  logic [SUM_WIDTH-1:0]        q_avg;
  logic [PROD_W-1:0]           q_w;
  logic                        w_neg;
  logic signed [OFFSET_W-1:0]  diff_base;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Window bookkeeping
  assign count_eff    = (avg_count_r == '0) ? COUNT_W'(1) : avg_count_r;
  assign taken_inc    = taken_r + COUNT_W'(1);
  assign sample_ext   = SUM_WIDTH'(in_data.sample);
  assign elapsed_inc  = (elapsed_r == {ELAPSED_W{1'b1}}) ? elapsed_r
                                                         : elapsed_r + ELAPSED_W'(1);
  assign tick_timeout = elapsed_inc > ELAPSED_W'(timeout_r);

  // Operand magnitudes for the unsigned divider
  assign sum_mag  = sum_r[SUM_WIDTH-1] ? (~sum_r + SUM_WIDTH'(1)) : sum_r;
  assign cal_mag  = cal_r[CAL_W-1] ? (~cal_r + CAL_W'(1)) : cal_r;
  assign diff_mag = diff_r[DIFF_W-1] ? (~diff_r + DIFF_W'(1)) : diff_r;
  assign prod_mag = PROD_W'(diff_mag) << FRAC_SHIFT;
  assign w_neg    = diff_r[DIFF_W-1] ^ cal_r[CAL_W-1];

  assign q_avg = div_rsp.quotient[SUM_WIDTH-1:0];
  assign q_w   = div_rsp.quotient[PROD_W-1:0];

  // Clamp below the tare point when negative readings are off
  assign diff_base = (!allow_neg_r && (avg_r < zero_offset_r)) ? zero_offset_r : avg_r;

  // Divider request: mean first, then weight; dividends are left aligned
  always_comb begin
    div_req.start = (state_r == S_START1) || (state_r == S_START2 && cal_r != '0);
    if (state_r == S_START1) begin
      div_req.steps    = STEP_W'(SUM_WIDTH);
      div_req.dividend = DIVD_W'(sum_mag) << (DIVD_W - SUM_WIDTH);
      div_req.divisor  = DVS_W'(count_eff);
    end else begin
      div_req.steps    = STEP_W'(PROD_W);
      div_req.dividend = DIVD_W'(prod_mag) << (DIVD_W - PROD_W);
      div_req.divisor  = DVS_W'(cal_mag);
    end
  end

  lcats_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer and next-value logic
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    taken_nxt     = taken_r;
    elapsed_nxt   = elapsed_r;
    avg_nxt       = avg_r;
    diff_nxt      = diff_r;
    weight_nxt    = weight_r;
    to_nxt        = to_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.opcode == lcats_pkg::OP_TICK) begin
            elapsed_nxt = elapsed_inc;
            if (tick_timeout) begin
              avg_nxt    = '0;
              weight_nxt = '0;
              to_nxt     = 1'b1;
              err_nxt    = 1'b0;
              state_nxt  = S_DONE;
            end
          end else begin
            sum_nxt   = sum_r + sample_ext;
            taken_nxt = taken_inc;
            if (taken_inc == count_eff) begin
              state_nxt = S_START1;
            end
          end
        end
      end
      S_START1: begin
        state_nxt = S_WAIT1;
      end
      S_WAIT1: begin
        // Restore the sign of the mean and saturate to the sample range
        if (div_rsp.done) begin
          if (sum_r[SUM_WIDTH-1]) begin
            avg_nxt = (q_avg > AVG_LIM + SUM_WIDTH'(1)) ? AVG_MIN
                                                        : ~q_avg[AVG_W-1:0] + AVG_W'(1);
          end else begin
            avg_nxt = (q_avg > AVG_LIM) ? AVG_MAX : q_avg[AVG_W-1:0];
          end
          to_nxt    = 1'b0;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        diff_nxt  = DIFF_W'(diff_base) - DIFF_W'(zero_offset_r);
        state_nxt = S_START2;
      end
      S_START2: begin
        // Zero factor: flag it and skip the division
        if (cal_r == '0) begin
          weight_nxt = '0;
          err_nxt    = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_WAIT2;
        end
      end
      S_WAIT2: begin
        // Restore the sign of the weight and saturate to 32 bits
        if (div_rsp.done) begin
          if (w_neg) begin
            err_nxt    = q_w > W_LIM + PROD_W'(1);
            weight_nxt = err_nxt ? W_MIN : ~q_w[WEIGHT_W-1:0] + WEIGHT_W'(1);
          end else begin
            err_nxt    = q_w > W_LIM;
            weight_nxt = err_nxt ? W_MAX : q_w[WEIGHT_W-1:0];
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result to the output register and open a new window
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.average     = avg_r;
          out_data_nxt.weight_q8   = weight_r;
          out_data_nxt.timed_out   = to_r;
          out_data_nxt.range_error = err_r;
          sum_nxt                  = '0;
          taken_nxt                = '0;
          elapsed_nxt              = '0;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, window state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      sum_r         <= '0;
      taken_r       <= '0;
      elapsed_r     <= '0;
      avg_count_r   <= lcats_pkg::RST_AVERAGE_COUNT;
      zero_offset_r <= lcats_pkg::RST_ZERO_OFFSET;
      cal_r         <= lcats_pkg::RST_CAL_FACTOR;
      allow_neg_r   <= lcats_pkg::RST_ALLOW_NEGATIVE;
      timeout_r     <= lcats_pkg::RST_TIMEOUT_TICKS;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      taken_r     <= taken_nxt;
      elapsed_r   <= elapsed_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          lcats_pkg::CFG_AVERAGE_COUNT:  avg_count_r   <= cfg_data[COUNT_W-1:0];
          lcats_pkg::CFG_ZERO_OFFSET:    zero_offset_r <= cfg_data[OFFSET_W-1:0];
          lcats_pkg::CFG_CAL_FACTOR:     cal_r         <= cfg_data[CAL_W-1:0];
          lcats_pkg::CFG_ALLOW_NEGATIVE: allow_neg_r   <= cfg_data[0];
          lcats_pkg::CFG_TIMEOUT_TICKS:  timeout_r     <= cfg_data[TIMEOUT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    avg_r      <= avg_nxt;
    diff_r     <= diff_nxt;
    weight_r   <= weight_nxt;
    to_r       <= to_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  ap_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_WAIT1 || state_r == S_WAIT2))
    else $error("divider finished outside a wait state");

  ap_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  ap_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.timed_out) |->
      (out_data_r.weight_q8 == '0 && out_data_r.average == '0 && !out_data_r.range_error))
    else $error("timeout result carries nonzero payload");

  ap_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (sum_r == '0 && taken_r == '0 && elapsed_r == '0))
    else $error("window not cleared after result");
`endif

endmodule

`default_nettype wire

// ===== sv/lcats_div.sv =====
`default_nettype none

module lcats_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lcats_pkg::div_req_t req,
  output lcats_pkg::div_rsp_t      rsp
);

  localparam int DIVD_W = lcats_pkg::DIVD_W;
  localparam int DVS_W  = lcats_pkg::DVS_W;
  localparam int STEP_W = lcats_pkg::STEP_W;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DVS_W-1:0]  dvs_r;

  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  trial;
  logic              borrow;
  logic [DVS_W-1:0]  rem_nxt;
  logic [DIVD_W-1:0] quo_nxt;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem_r, quo_r[DIVD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
    borrow  = trial[DVS_W+1];
    rem_nxt = borrow ? shifted[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_nxt = {quo_r[DIVD_W-2:0], ~borrow};
  end

  // Control: busy while steps remain, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: load operands, then advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= req.steps;
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - STEP_W'(1);
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire
